### sv/afk_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and reciprocal tables for the arm forward kinematics unit.
// No dependencies; imported by every module of the block.
package afk_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 15;

  localparam int ANG_W   = 16;
  localparam int LEN_W   = 14;
  localparam int POS_W   = 16;
  localparam int Q_FRAC  = 30;
  localparam int X_W     = 31;
  localparam int X2_W    = 32;
  localparam int T_W     = 31;
  localparam int V_W     = 32;
  localparam int MAG_W   = 40;
  localparam int TRIG_W  = TRIG_FRAC_BITS + 1;

  localparam int SIN_STEPS = 6;
  localparam int COS_STEPS = 7;
  // x, x^2, cos Horner steps, cos finish, quadrant
  localparam int TRIG_LAT  = 2 + 2 * COS_STEPS + 1 + 1;

  localparam logic [ANG_W-1:0] QUARTER_TURN = 16'h4000;
  localparam logic [X_W-1:0]   HALF_PI_Q30  = 31'd1686629713;
  localparam logic [T_W-1:0]   Q_ONE        = 31'h4000_0000;

  // ceil(2^40 / d) for the Taylor divisors
  localparam logic [MAG_W-1:0] SIN_MAGIC [SIN_STEPS] = '{
    40'd7048151461, 40'd9995560253, 40'd15270994831,
    40'd26178848281, 40'd54975581389, 40'd183251937963
  };
  localparam logic [MAG_W-1:0] COS_MAGIC [COS_STEPS] = '{
    40'd6041272681, 40'd8329633544, 40'd12216795865, 40'd19634136211,
    40'd36650387593, 40'd91625968982, 40'd549755813888
  };

  typedef enum logic [1:0] {
    REG_UPPER_ARM   = 2'd0,
    REG_FOREARM     = 2'd1,
    REG_WRIST       = 2'd2,
    REG_BASE_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef logic signed [TRIG_W-1:0] trig_t;

endpackage

### sv/arm_forward_kinematics_unit.sv
`timescale 1ns / 1ps
// Top level of the arm forward kinematics unit: joint sums, four trig pipes, link sums, output.
// Depends on afk_pkg and afk_trig.
//
//   channel   direction  handshake              payload
//   in        input      in_valid_i/in_ready_o  base/shoulder/elbow/wrist_angle_i
//   out       output     out_valid_o/out_ready_i x_pos_o, y_pos_o, z_pos_o
//   cfg       input      cfg_we_i (no wait)     cfg_idx_i, cfg_data_i
//
// There are 23 register stages; the 18-stage sine/cosine pipe (fourteen Horner stages for
// the cosine series) makes up most of them.
// One transaction enters per cycle while the output is not stalled. Each stage stalls only when it holds a
// valid item and the stage after it is stalled, so bubbles close up.
// Reset clears all valid bits and loads the default link lengths.
module arm_forward_kinematics_unit import afk_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [ANG_W-1:0] base_angle_i,
  input  logic signed [ANG_W-1:0] shoulder_angle_i,
  input  logic signed [ANG_W-1:0] elbow_angle_i,
  input  logic signed [ANG_W-1:0] wrist_angle_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [POS_W-1:0] x_pos_o,
  output logic signed [POS_W-1:0] y_pos_o,
  output logic signed [POS_W-1:0] z_pos_o,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [LEN_W-1:0]        cfg_data_i
);

  localparam int NST   = 1 + TRIG_LAT + 4;
  localparam int ST_P1 = 1 + TRIG_LAT;
  localparam int PW    = LEN_W + 1 + TRIG_W;
  localparam int SW    = PW + 3;
  localparam int R_W   = SW - TRIG_FRAC_BITS;
  localparam int XP_W  = TRIG_W + R_W;
  localparam int SAT_W = R_W + 1;
  localparam logic signed [SW-1:0]    HALF_S = SW'(1) << (TRIG_FRAC_BITS - 1);
  localparam logic signed [XP_W-1:0]  HALF_X = XP_W'(1) << (TRIG_FRAC_BITS - 1);
  localparam logic signed [SAT_W-1:0] POS_MAX = SAT_W'(32767);
  localparam logic signed [SAT_W-1:0] POS_MIN = SAT_W'(-32768);

  function automatic logic signed [POS_W-1:0] sat16(input logic signed [SAT_W-1:0] v);
    if (v > POS_MAX) begin
      sat16 = POS_MAX[POS_W-1:0];
    end else if (v < POS_MIN) begin
      sat16 = POS_MIN[POS_W-1:0];
    end else begin
      sat16 = v[POS_W-1:0];
    end
  endfunction

  logic [LEN_W-1:0] l1_q, l2_q, l3_q, h_q;
  logic [NST-1:0]   vld_q;
  logic [NST:0]     rdy;
  logic [ANG_W-1:0] a0_q, a1_q, a12_q, a123_q;
  logic [ANG_W-1:0] a1_d, a12_d, a123_d;
  trig_t            s0, c0, s1, c1, s12, c12, s123, c123;

  // link products, sums and final products
  logic signed [PW-1:0]    pc1_q, pc12_q, ps123_q, ps1_q, ps12_q, pc123_q;
  trig_t                   s0p_q, c0p_q, s0r_q, c0r_q;
  logic signed [LEN_W:0]   l1s, l2s, l3s;
  logic signed [SW-1:0]    rsum, zsum, rsh, zsh;
  logic signed [R_W-1:0]   r_q;
  logic signed [SAT_W-1:0] z_d, z_q, z2_q;
  logic signed [XP_W-1:0]  xp_q, yp_q, xr, yr;
  logic signed [SAT_W-1:0] xs, ys;
  logic signed [POS_W-1:0] x_q, y_q, zo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q <= LEN_W'(6226);
      l2_q <= LEN_W'(6226);
      l3_q <= LEN_W'(8520);
      h_q  <= LEN_W'(4260);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_UPPER_ARM:   l1_q <= cfg_data_i;
        REG_FOREARM:     l2_q <= cfg_data_i;
        REG_WRIST:       l3_q <= cfg_data_i;
        REG_BASE_HEIGHT: h_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ready ripples back: a stage loads when empty or when its successor loads
  always_comb begin
    rdy[NST] = out_ready_i;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NST-1];

  // joint angle sums with quarter-turn offsets, modulo one turn
  assign a1_d   = shoulder_angle_i + QUARTER_TURN;
  assign a12_d  = a1_d + elbow_angle_i;
  assign a123_d = a12_d + wrist_angle_i - QUARTER_TURN;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      a0_q   <= base_angle_i;
      a1_q   <= a1_d;
      a12_q  <= a12_d;
      a123_q <= a123_d;
    end
  end

  afk_trig u_trig0 (.clk_i(clk_i), .en_i(rdy[TRIG_LAT:1]), .angle_i(a0_q),
                    .sin_o(s0), .cos_o(c0));
  afk_trig u_trig1 (.clk_i(clk_i), .en_i(rdy[TRIG_LAT:1]), .angle_i(a1_q),
                    .sin_o(s1), .cos_o(c1));
  afk_trig u_trig12 (.clk_i(clk_i), .en_i(rdy[TRIG_LAT:1]), .angle_i(a12_q),
                     .sin_o(s12), .cos_o(c12));
  afk_trig u_trig123 (.clk_i(clk_i), .en_i(rdy[TRIG_LAT:1]), .angle_i(a123_q),
                      .sin_o(s123), .cos_o(c123));

  assign l1s = {1'b0, l1_q};
  assign l2s = {1'b0, l2_q};
  assign l3s = {1'b0, l3_q};

  assign rsum = SW'(pc1_q) + SW'(pc12_q) - SW'(ps123_q) + HALF_S;
  assign zsum = SW'(ps1_q) + SW'(ps12_q) + SW'(pc123_q) + HALF_S;
  assign rsh  = rsum >>> TRIG_FRAC_BITS;
  assign zsh  = zsum >>> TRIG_FRAC_BITS;
  assign z_d  = SAT_W'($signed({1'b0, h_q})) + SAT_W'($signed(zsh[R_W-1:0]));

  assign xr = (xp_q + HALF_X) >>> TRIG_FRAC_BITS;
  assign yr = (yp_q + HALF_X) >>> TRIG_FRAC_BITS;
  assign xs = xr[SAT_W-1:0];
  assign ys = yr[SAT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (rdy[ST_P1]) begin
      pc1_q   <= l1s * c1;
      pc12_q  <= l2s * c12;
      ps123_q <= l3s * s123;
      ps1_q   <= l1s * s1;
      ps12_q  <= l2s * s12;
      pc123_q <= l3s * c123;
      s0p_q   <= s0;
      c0p_q   <= c0;
    end
    if (rdy[ST_P1+1]) begin
      r_q   <= rsh[R_W-1:0];
      z_q   <= z_d;
      s0r_q <= s0p_q;
      c0r_q <= c0p_q;
    end
    if (rdy[ST_P1+2]) begin
      xp_q <= XP_W'(c0r_q) * XP_W'(r_q);
      yp_q <= XP_W'(s0r_q) * XP_W'(r_q);
      z2_q <= z_q;
    end
    if (rdy[ST_P1+3]) begin
      x_q  <= sat16(xs);
      y_q  <= sat16(ys);
      zo_q <= sat16(z2_q);
    end
  end

  assign x_pos_o = x_q;
  assign y_pos_o = y_q;
  assign z_pos_o = zo_q;

endmodule

### sv/afk_horner.sv
`timescale 1ns / 1ps
// One Horner step of the Taylor series: t' = clamp(1 - floor(x2*t/2^30 / d)), two stages.
// Depends on afk_pkg.
module afk_horner import afk_pkg::*; (
  input  logic             clk_i,
  input  logic [1:0]       en_i,
  input  logic [X2_W-1:0]  x2_i,
  input  logic [T_W-1:0]   t_i,
  input  logic [MAG_W-1:0] magic_i,
  output logic [X2_W-1:0]  x2_o,
  output logic [T_W-1:0]   t_o
);

  logic [X2_W+T_W-1:0]   prod;
  logic [V_W-1:0]        v_d, v_q;
  logic [X2_W-1:0]       x2a_q, x2b_q;
  logic [V_W+MAG_W-1:0]  qprod;
  logic [V_W-1:0]        quo;
  logic [T_W-1:0]        t_d, t_q;

  assign prod = (X2_W+T_W)'(x2_i) * (X2_W+T_W)'(t_i);
  assign v_d  = prod[Q_FRAC+V_W-1:Q_FRAC];

  // divide by the constant through its reciprocal
  assign qprod = (V_W+MAG_W)'(v_q) * (V_W+MAG_W)'(magic_i);
  assign quo   = qprod[V_W+MAG_W-1:MAG_W];

  always_comb begin
    if (quo > V_W'(Q_ONE)) begin
      t_d = '0;
    end else begin
      t_d = Q_ONE - T_W'(quo);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      v_q   <= v_d;
      x2a_q <= x2_i;
    end
    if (en_i[1]) begin
      t_q   <= t_d;
      x2b_q <= x2a_q;
    end
  end

  assign x2_o = x2b_q;
  assign t_o  = t_q;

endmodule

### sv/afk_trig.sv
`timescale 1ns / 1ps
// Pipelined sine and cosine of a binary angle: quadrant split, Taylor series, rounding.
// Depends on afk_pkg and afk_horner.
module afk_trig import afk_pkg::*; (
  input  logic                clk_i,
  input  logic [TRIG_LAT-1:0] en_i,
  input  logic [ANG_W-1:0]    angle_i,
  output trig_t               sin_o,
  output trig_t               cos_o
);

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_e;

  localparam int PH_W   = ANGLE_BITS - 2;
  localparam int XP_W   = PH_W + X_W + 1;
  localparam int SIN_FIN = 2 + 2 * SIN_STEPS;
  localparam int COS_FIN = 2 + 2 * COS_STEPS;
  localparam int RND_SH = Q_FRAC - TRIG_FRAC_BITS;

  function automatic logic [TRIG_FRAC_BITS-1:0] to_trig(input logic [T_W-1:0] v);
    logic [T_W:0] r;
    r = ((T_W+1)'(v) + ((T_W+1)'(1) << (RND_SH - 1))) >> RND_SH;
    if (r > (T_W+1)'({TRIG_FRAC_BITS{1'b1}})) begin
      to_trig = '1;
    end else begin
      to_trig = r[TRIG_FRAC_BITS-1:0];
    end
  endfunction

  logic [23:0]            ext;
  logic [ANGLE_BITS-1:0]  ang;
  logic [XP_W-1:0]        xprod;
  logic [X_W-1:0]         x_q [SIN_FIN];
  quad_e                  quad_q [TRIG_LAT-1];
  logic [2*X_W-1:0]       xx;
  logic [X2_W-1:0]        x2_q;
  logic [X2_W-1:0]        sin_x2 [SIN_STEPS];
  logic [T_W-1:0]         sin_t  [SIN_STEPS+1];
  logic [X2_W-1:0]        cos_x2 [COS_STEPS];
  logic [T_W-1:0]         cos_t  [COS_STEPS+1];
  logic [2*X_W-1:0]       sx;
  logic [T_W-1:0]         s_raw;
  logic [TRIG_FRAC_BITS-1:0] sin_mag_q [COS_FIN - SIN_FIN + 1];
  logic [TRIG_FRAC_BITS-1:0] cos_mag_q;
  trig_t                  s_pos, c_pos, sin_q, cos_q;

  assign ext   = {angle_i, 8'h00} >> (24 - ANGLE_BITS);
  assign ang   = ext[ANGLE_BITS-1:0];
  assign xprod = (XP_W'(ang[PH_W-1:0]) * XP_W'(HALF_PI_Q30) + (XP_W'(1) << (PH_W - 1)))
                 >> PH_W;
  assign xx    = (2*X_W)'(x_q[0]) * (2*X_W)'(x_q[0]);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x_q[0]    <= xprod[X_W-1:0];
      quad_q[0] <= quad_e'(ang[ANGLE_BITS-1:ANGLE_BITS-2]);
    end
    if (en_i[1]) begin
      x2_q <= xx[Q_FRAC+X2_W-1:Q_FRAC];
    end
    for (int k = 1; k < SIN_FIN; k++) begin
      if (en_i[k]) begin
        x_q[k] <= x_q[k-1];
      end
    end
    for (int k = 1; k < TRIG_LAT - 1; k++) begin
      if (en_i[k]) begin
        quad_q[k] <= quad_q[k-1];
      end
    end
  end

  assign sin_x2[0] = x2_q;
  assign sin_t[0]  = Q_ONE;
  assign cos_x2[0] = x2_q;
  assign cos_t[0]  = Q_ONE;

  for (genvar i = 0; i < SIN_STEPS; i++) begin : g_sin
    if (i < SIN_STEPS - 1) begin : g_mid
      afk_horner u_step (
        .clk_i  (clk_i),
        .en_i   (en_i[2*i+3:2*i+2]),
        .x2_i   (sin_x2[i]),
        .t_i    (sin_t[i]),
        .magic_i(SIN_MAGIC[i]),
        .x2_o   (sin_x2[i+1]),
        .t_o    (sin_t[i+1])
      );
    end else begin : g_last
      afk_horner u_step (
        .clk_i  (clk_i),
        .en_i   (en_i[2*i+3:2*i+2]),
        .x2_i   (sin_x2[i]),
        .t_i    (sin_t[i]),
        .magic_i(SIN_MAGIC[i]),
        .x2_o   (),
        .t_o    (sin_t[i+1])
      );
    end
  end

  for (genvar i = 0; i < COS_STEPS; i++) begin : g_cos
    if (i < COS_STEPS - 1) begin : g_mid
      afk_horner u_step (
        .clk_i  (clk_i),
        .en_i   (en_i[2*i+3:2*i+2]),
        .x2_i   (cos_x2[i]),
        .t_i    (cos_t[i]),
        .magic_i(COS_MAGIC[i]),
        .x2_o   (cos_x2[i+1]),
        .t_o    (cos_t[i+1])
      );
    end else begin : g_last
      afk_horner u_step (
        .clk_i  (clk_i),
        .en_i   (en_i[2*i+3:2*i+2]),
        .x2_i   (cos_x2[i]),
        .t_i    (cos_t[i]),
        .magic_i(COS_MAGIC[i]),
        .x2_o   (),
        .t_o    (cos_t[i+1])
      );
    end
  end

  // sine finish: multiply back by x, clamp to one
  assign sx = (2*X_W)'(x_q[SIN_FIN-1]) * (2*X_W)'(sin_t[SIN_STEPS]);
  always_comb begin
    if (sx[2*X_W-1:Q_FRAC] > (2*X_W-Q_FRAC)'(Q_ONE)) begin
      s_raw = Q_ONE;
    end else begin
      s_raw = sx[Q_FRAC+T_W-1:Q_FRAC];
    end
  end

  assign s_pos = trig_t'({1'b0, sin_mag_q[COS_FIN-SIN_FIN]});
  assign c_pos = trig_t'({1'b0, cos_mag_q});

  always_ff @(posedge clk_i) begin
    if (en_i[SIN_FIN]) begin
      sin_mag_q[0] <= to_trig(s_raw);
    end
    for (int k = 1; k <= COS_FIN - SIN_FIN; k++) begin
      if (en_i[SIN_FIN+k]) begin
        sin_mag_q[k] <= sin_mag_q[k-1];
      end
    end
    if (en_i[COS_FIN]) begin
      cos_mag_q <= to_trig(cos_t[COS_STEPS]);
    end
    if (en_i[TRIG_LAT-1]) begin
      case (quad_q[TRIG_LAT-2])
        QUAD_0: begin sin_q <= s_pos;  cos_q <= c_pos;  end
        QUAD_1: begin sin_q <= c_pos;  cos_q <= -s_pos; end
        QUAD_2: begin sin_q <= -s_pos; cos_q <= -c_pos; end
        QUAD_3: begin sin_q <= -c_pos; cos_q <= s_pos;  end
        default: begin sin_q <= s_pos; cos_q <= c_pos;  end
      endcase
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

### tb/arm_forward_kinematics_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for arm_forward_kinematics_unit: random and directed joint vectors,
// bursty sender, stalling receiver, bit-exact position predictor. Depends on afk_pkg.
module arm_forward_kinematics_unit_test;
  import afk_pkg::*;

  typedef struct packed {
    logic signed [ANG_W-1:0] base;
    logic signed [ANG_W-1:0] shoulder;
    logic signed [ANG_W-1:0] elbow;
    logic signed [ANG_W-1:0] wrist;
  } joints_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } tool_pos_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [ANG_W-1:0] base_angle_i = '0, shoulder_angle_i = '0;
  logic signed [ANG_W-1:0] elbow_angle_i = '0, wrist_angle_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [POS_W-1:0] x_pos_o, y_pos_o, z_pos_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = REG_UPPER_ARM;
  logic [LEN_W-1:0] cfg_data_i = '0;

  arm_forward_kinematics_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  joints_t   joint_q[$];
  tool_pos_t pos_q[$];
  longint    len_l1 = 6226, len_l2 = 6226, len_l3 = 8520, height = 4260;
  int        mismatch_cnt = 0;
  int        idle_cycles = 0;
  bit        in_taken = 1'b0;
  bit        sender_hold = 1'b0;
  bit        long_hold_req = 1'b0;
  int        burst_left = 4, gap_left = 0;
  int        hold_cnt = 0, stall_mode = 0, mode_cnt = 0;

  localparam longint QONE = 64'sd1 << 30;
  localparam longint HALF_PI = 64'sd1686629713;

  function automatic longint clamp_unit(longint v);
    if (v < 0) return 0;
    if (v > QONE) return QONE;
    return v;
  endfunction

  function automatic longint to_q15(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    return (r > 32767) ? 32767 : r;
  endfunction

  function automatic void sin_cos(input logic [15:0] a, output longint s_o, output longint c_o);
    longint sdiv[6] = '{156, 110, 72, 42, 20, 6};
    longint cdiv[7] = '{182, 132, 90, 56, 30, 12, 2};
    longint x, x2, t, s, c, p;
    p = longint'(a[13:0]);
    x = (p * HALF_PI + 8192) >>> 14;
    x2 = (x * x) >>> 30;
    t = QONE;
    for (int i = 0; i < 6; i++) t = QONE - (((x2 * t) / sdiv[i]) >>> 30);
    s = to_q15(clamp_unit((x * t) >>> 30));
    t = QONE;
    for (int i = 0; i < 7; i++) begin
      t = QONE - (((x2 * t) / cdiv[i]) >>> 30);
      if (i < 6) t = clamp_unit(t);
    end
    c = to_q15(clamp_unit(t));
    case (a[15:14])
      2'd0: begin s_o = s;  c_o = c;  end
      2'd1: begin s_o = c;  c_o = -s; end
      2'd2: begin s_o = -s; c_o = -c; end
      default: begin s_o = -c; c_o = s; end
    endcase
  endfunction

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic tool_pos_t tool_position(joints_t j);
    logic [15:0] a1, a12, a123;
    longint s0, c0, s1, c1, s12, c12, s123, c123, r, zl;
    tool_pos_t p;
    a1 = j.shoulder + QUARTER_TURN;
    a12 = a1 + j.elbow;
    a123 = a12 + j.wrist - QUARTER_TURN;
    sin_cos(j.base, s0, c0);
    sin_cos(a1, s1, c1);
    sin_cos(a12, s12, c12);
    sin_cos(a123, s123, c123);
    r = (len_l1 * c1 + len_l2 * c12 - len_l3 * s123 + 16384) >>> 15;
    zl = (len_l1 * s1 + len_l2 * s12 + len_l3 * c123 + 16384) >>> 15;
    p.x = sat16((c0 * r + 16384) >>> 15);
    p.y = sat16((s0 * r + 16384) >>> 15);
    p.z = sat16(height + zl);
    return p;
  endfunction

  // Monitor: predict on input transactions, check output transactions, watchdog.
  always @(posedge clk_i) begin
    tool_pos_t want;
    in_taken = in_valid_i && in_ready_o;
    if (in_taken)
      pos_q.push_back(tool_position({base_angle_i, shoulder_angle_i,
                                     elbow_angle_i, wrist_angle_i}));
    if (out_valid_o && out_ready_i) begin
      if (pos_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time,
                 x_pos_o, y_pos_o, z_pos_o);
        mismatch_cnt++;
      end else begin
        want = pos_q.pop_front();
        if (want.x !== x_pos_o) begin
          $display("%0t: x_pos expected %0d actual %0d", $time, want.x, x_pos_o);
          mismatch_cnt++;
        end
        if (want.y !== y_pos_o) begin
          $display("%0t: y_pos expected %0d actual %0d", $time, want.y, y_pos_o);
          mismatch_cnt++;
        end
        if (want.z !== z_pos_o) begin
          $display("%0t: z_pos expected %0d actual %0d", $time, want.z, z_pos_o);
          mismatch_cnt++;
        end
      end
    end
    if (in_taken || (out_valid_o && out_ready_i) || !rst_ni) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= 20000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Driver: bursts with random gaps, holds payload until the transaction completes.
  always @(negedge clk_i) begin
    joints_t j;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (joint_q.size() > 0 && !sender_hold) begin
        j = joint_q.pop_front();
        in_valid_i <= 1'b1;
        base_angle_i <= j.base;
        shoulder_angle_i <= j.shoulder;
        elbow_angle_i <= j.elbow;
        wrist_angle_i <= j.wrist;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: ready follows a randomly re-chosen stall pattern; long hold-off on request.
  always @(negedge clk_i) begin
    if (long_hold_req && hold_cnt == 0) begin
      hold_cnt = 400;
      long_hold_req = 1'b0;
    end
    if (++mode_cnt >= 64) begin
      mode_cnt = 0;
      stall_mode = $urandom_range(0, 2);
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 9) < 7);
        default: out_ready_i <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  task automatic add_joints(int b, int s, int e, int w);
    joint_q.push_back({16'(b), 16'(s), 16'(e), 16'(w)});
  endtask

  function automatic logic [15:0] pick_angle();
    logic [15:0] corner[8] = '{16'h0000, 16'h8000, 16'h7FFF, 16'h4000,
                               16'hC000, 16'h2000, 16'hFFFF, 16'h0001};
    if ($urandom_range(0, 7) == 0) return corner[$urandom_range(0, 7)];
    return 16'($urandom);
  endfunction

  task automatic add_random(int n);
    repeat (n) joint_q.push_back({pick_angle(), pick_angle(), pick_angle(), pick_angle()});
  endtask

  task automatic drain();
    wait (joint_q.size() == 0 && !in_valid_i && pos_q.size() == 0);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_lengths(int l1, int l2, int l3, int h);
    int vals[4];
    vals = '{l1, l2, l3, h};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= 2'(i);
      cfg_data_i <= 14'(vals[i]);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    len_l1 = l1; len_l2 = l2; len_l3 = l3; height = h;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: quadrant corners, wrap-around, extremes.
    add_joints(0, 0, 0, 0);
    add_joints(16384, 0, 0, 0);
    add_joints(-32768, 0, 0, 0);
    add_joints(-16384, -16384, 0, 16384);
    add_joints(32767, 32767, 32767, 32767);
    add_joints(-32768, -32768, -32768, -32768);
    add_joints(8192, 8192, 8192, 8192);
    add_joints(-1, -1, -1, -1);
    add_joints(1, 1, 1, 1);
    add_joints(0, -16384, 0, 16384);
    add_joints(0, 16384, -32768, 0);
    add_joints(4096, 12288, -20480, 28672);
    drain();

    set_lengths(16383, 16383, 16383, 16383);
    add_joints(0, -16384, 0, 16384);
    add_joints(0, -16384, 0, -16384);
    add_joints(16384, -16384, 0, 16384);
    add_joints(-32768, -16384, 0, 16384);
    add_joints(0, 0, 0, 0);
    add_joints(-16384, 16384, 0, 0);
    add_random(300);
    long_hold_req = 1'b1;
    drain();

    set_lengths(0, 0, 0, 0);
    add_random(150);
    drain();

    set_lengths(6226, 6226, 8520, 4260);
    add_random(300);
    // Stop offering mid-phase until every result is back.
    wait (joint_q.size() < 150);
    sender_hold = 1'b1;
    wait (pos_q.size() == 0);
    sender_hold = 1'b0;
    drain();

    repeat (3) begin
      set_lengths($urandom_range(0, 16383), $urandom_range(0, 16383),
                  $urandom_range(0, 16383), $urandom_range(0, 16383));
      add_random(250);
      drain();
    end

    if (mismatch_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
